@@ rtl/rrl_pkg.sv @@
// Shared constants for the restart rate limiter: field widths, operation
// and deny codes, configuration register indexes and reset values.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rrl_pkg;

    // payload field widths
    localparam int FUNC_W      = 2;
    localparam int UNIT_ID_W   = 4;
    localparam int NOW_W       = 32;
    localparam int REASON_W    = 2;
    localparam int COUNT_W     = 6;

    // configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SEC_W       = 16;
    localparam int ATT_LIM_W   = 8;
    localparam int ATT_FLOOR_W = 6;

    // default sizing
    localparam int NUM_UNITS_DEF = 16;
    localparam int LOG_DEPTH_DEF = 8;
    localparam int TIME_BITS_DEF = 32;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECORD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    // deny reasons
    localparam logic [REASON_W-1:0] REASON_NONE     = 2'd0;
    localparam logic [REASON_W-1:0] REASON_TOO_SOON = 2'd1;
    localparam logic [REASON_W-1:0] REASON_LIMIT    = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTEMPT_FLOOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_FLOOR     = 3'd5;

    // register reset values
    localparam logic [SEC_W-1:0]       RST_WINDOW_LENGTH = 16'd0;
    localparam logic [SEC_W-1:0]       RST_WINDOW_FLOOR  = 16'd10;
    localparam logic [ATT_LIM_W-1:0]   RST_ATTEMPT_LIMIT = 8'd0;
    localparam logic [ATT_FLOOR_W-1:0] RST_ATTEMPT_FLOOR = 6'd5;
    localparam logic [SEC_W-1:0]       RST_MIN_GAP       = 16'd0;
    localparam logic [SEC_W-1:0]       RST_GAP_FLOOR     = 16'd1;

endpackage

`default_nettype wire

@@ rtl/rrl_req_if.sv @@
// Request channel of the restart rate limiter: valid/ready plus one request word.
// Depends on rrl_pkg for the field widths.
`default_nettype none

interface rrl_req_if import rrl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [UNIT_ID_W-1:0] unit_id;
    logic [NOW_W-1:0]     now_sec;

    modport source (output valid, func, unit_id, now_sec, input ready);
    modport sink   (input valid, func, unit_id, now_sec, output ready);
endinterface

`default_nettype wire

@@ rtl/rrl_rsp_if.sv @@
// Response channel of the restart rate limiter: valid/ready plus one result word.
// Depends on rrl_pkg for the field widths.
`default_nettype none

interface rrl_rsp_if import rrl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                allowed;
    logic [REASON_W-1:0] deny_reason;
    logic [COUNT_W-1:0]  logged_count;

    modport source (output valid, allowed, deny_reason, logged_count, input ready);
    modport sink   (input valid, allowed, deny_reason, logged_count, output ready);
endinterface

`default_nettype wire

@@ rtl/restart_rate_limiter_unit.sv @@
// Restart rate limiter top level: per-unit sliding-window log of attempt times.
// Depends on rrl_pkg, rrl_req_if and rrl_rsp_if.
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+-----------------------------------
//  i_req     | in  | valid/ready        | func, unit_id, now_sec
//  o_rsp     | out | valid/ready        | allowed, deny_reason, logged_count
//  i_cfg_*   | in  | write enable only  | register index, 16-bit data
//
// One word at a time. A check that passes the gap test and a record into a full
// log scan the log memory, one entry per cycle through the shared
// subtract/compare unit; every other word goes straight to write-back.
// The result sits in an output register, so a new word is taken while it waits;
// the block stalls only at write-back if that register is still full.
// Reset is synchronous and needs no clearing pass: per-unit valid bits stand
// in for the cleared count/last table, and log entries are only read below
// the count.
`default_nettype none

module restart_rate_limiter_unit import rrl_pkg::*; #(
    parameter int NUM_UNITS = NUM_UNITS_DEF,
    parameter int LOG_DEPTH = LOG_DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    rrl_req_if.sink                    i_req,
    rrl_rsp_if.source                  o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int IDX_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
    localparam int DEPTH  = NUM_UNITS * LOG_DEPTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_POST} t_state;

    typedef struct packed {
        logic [CNT_W-1:0]     cnt;
        logic [TIME_BITS-1:0] last;
    } t_unit_rec;

    // unit index wraps modulo NUM_UNITS; at most eight subtractions for 4 bits
    function automatic logic [UNIT_W-1:0] wrap_unit(input logic [UNIT_ID_W-1:0] id);
        logic [8:0] u;
        u = 9'(id);
        for (int k = 0; k < 8; k++) begin
            if (u >= 9'(NUM_UNITS)) begin
                u = u - 9'(NUM_UNITS);
            end
        end
        return UNIT_W'(u);
    endfunction

    function automatic logic [ADDR_W-1:0] log_addr(input logic [UNIT_W-1:0] u,
                                                   input logic [CNT_W-1:0]  i);
        return ADDR_W'(ADDR_W'(u) * ADDR_W'(LOG_DEPTH) + ADDR_W'(i[IDX_W-1:0]));
    endfunction

    // configuration
    logic [SEC_W-1:0]       r_win_len, r_win_floor, r_min_gap, r_gap_floor;
    logic [ATT_LIM_W-1:0]   r_att_lim;
    logic [ATT_FLOOR_W-1:0] r_att_floor;

    // sequencer and output registers
    t_state                 r_state, n_state;
    logic [FUNC_W-1:0]      r_func, n_func;
    logic [UNIT_W-1:0]      r_unit, n_unit;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [TIME_BITS-1:0]   r_last, n_last;
    logic [CNT_W-1:0]       r_rd, n_rd;
    logic [CNT_W-1:0]       r_end, n_end;
    logic [CNT_W-1:0]       r_wr, n_wr;
    logic                   r_pend, n_pend;
    logic                   r_deny1, n_deny1;
    logic [NUM_UNITS-1:0]   r_uvalid, n_uvalid;
    logic                   r_ov, n_ov;
    logic                   r_allowed, n_allowed;
    logic [REASON_W-1:0]    r_reason, n_reason;
    logic [COUNT_W-1:0]     r_count, n_count;

    // memories
    logic [TIME_BITS-1:0]   r_log_mem [DEPTH];
    logic [TIME_BITS-1:0]   r_log_q;
    t_unit_rec              r_rec_mem [NUM_UNITS];
    t_unit_rec              r_rec_q;

    logic                   req_acc;
    logic [UNIT_W-1:0]      req_unit;
    logic                   log_we;
    logic [ADDR_W-1:0]      log_wa, log_ra;
    logic [TIME_BITS-1:0]   log_wd;
    logic                   rec_we;
    t_unit_rec              rec_wd;
    t_unit_rec              rec_cur;

    logic [SEC_W-1:0]       win, gap, cmp_th;
    logic [ATT_LIM_W-1:0]   lim8;
    logic [CNT_W-1:0]       lim;
    logic [TIME_BITS-1:0]   cmp_x, cmp_diff;
    logic                   cmp_recent;

    assign req_acc  = i_req.valid && i_req.ready;
    assign req_unit = wrap_unit(i_req.unit_id);
    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid        = r_ov;
    assign o_rsp.allowed      = r_allowed;
    assign o_rsp.deny_reason  = r_reason;
    assign o_rsp.logged_count = r_count;

    // effective limits
    assign win  = (r_win_len > r_win_floor) ? r_win_len : r_win_floor;
    assign gap  = (r_min_gap > r_gap_floor) ? r_min_gap : r_gap_floor;
    assign lim8 = (r_att_lim > ATT_LIM_W'(r_att_floor)) ? r_att_lim : ATT_LIM_W'(r_att_floor);
    assign lim  = (lim8 > ATT_LIM_W'(LOG_DEPTH)) ? CNT_W'(LOG_DEPTH) : CNT_W'(lim8);

    assign rec_cur = r_uvalid[r_unit] ? r_rec_q : '0;

    // shared unit: is the time x still "recent" relative to now?
    // a time later than now always counts as recent
    assign cmp_x      = (r_state == S_SCAN) ? r_log_q : rec_cur.last;
    assign cmp_th     = (r_state == S_SCAN) ? win : gap;
    assign cmp_diff   = r_now - cmp_x;
    assign cmp_recent = (cmp_x > r_now) || (cmp_diff < TIME_BITS'(cmp_th));

    assign log_ra = log_addr(r_unit, r_rd);

    always_comb begin
        logic [CNT_W-1:0] kept;
        logic [CNT_W-1:0] inc;

        kept      = (r_wr > lim) ? lim : r_wr;
        inc       = CNT_W'(r_wr + 1'b1);

        n_state   = r_state;
        n_func    = r_func;
        n_unit    = r_unit;
        n_now     = r_now;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_rd      = r_rd;
        n_end     = r_end;
        n_wr      = r_wr;
        n_pend    = r_pend;
        n_deny1   = r_deny1;
        n_uvalid  = r_uvalid;
        n_ov      = r_ov && !o_rsp.ready;
        n_allowed = r_allowed;
        n_reason  = r_reason;
        n_count   = r_count;
        log_we    = 1'b0;
        log_wa    = log_addr(r_unit, r_wr);
        log_wd    = r_log_q;
        rec_we    = 1'b0;
        rec_wd    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    n_func  = i_req.func;
                    n_unit  = req_unit;
                    n_now   = TIME_BITS'(i_req.now_sec);
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_cnt   = rec_cur.cnt;
                n_last  = rec_cur.last;
                n_deny1 = 1'b0;
                n_pend  = 1'b0;
                n_rd    = '0;
                n_wr    = '0;
                n_end   = rec_cur.cnt;
                n_state = S_POST;
                case (r_func)
                    FUNC_CHECK: begin
                        if (rec_cur.last != '0 && cmp_recent) begin
                            n_deny1 = 1'b1;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FUNC_RECORD: begin
                        if (rec_cur.cnt < lim) begin
                            n_wr = rec_cur.cnt;
                        end else if (lim != '0) begin
                            // full log: shift entries 1..limit-1 down by one
                            n_rd    = CNT_W'(1);
                            n_end   = lim;
                            n_state = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (r_pend && (r_func != FUNC_CHECK || cmp_recent)) begin
                    log_we = 1'b1;
                    n_wr   = inc;
                end
                if (r_rd < r_end) begin
                    n_rd   = CNT_W'(r_rd + 1'b1);
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (!r_ov || o_rsp.ready) begin
                    n_state   = S_IDLE;
                    n_ov      = 1'b1;
                    n_allowed = 1'b0;
                    n_reason  = REASON_NONE;
                    n_count   = COUNT_W'(r_cnt);
                    case (r_func)
                        FUNC_CHECK: begin
                            if (r_deny1) begin
                                n_reason = REASON_TOO_SOON;
                            end else begin
                                rec_we  = 1'b1;
                                rec_wd  = '{cnt: kept, last: r_last};
                                n_count = COUNT_W'(kept);
                                if (kept >= lim) begin
                                    n_reason = REASON_LIMIT;
                                end else begin
                                    n_allowed = 1'b1;
                                end
                            end
                        end
                        FUNC_RECORD: begin
                            rec_we = 1'b1;
                            if (lim == '0) begin
                                rec_wd = '{cnt: r_cnt, last: r_now};
                            end else begin
                                log_we  = 1'b1;
                                log_wd  = r_now;
                                rec_wd  = '{cnt: inc, last: r_now};
                                n_count = COUNT_W'(inc);
                            end
                        end
                        FUNC_RELEASE: begin
                            n_count = '0;
                        end
                        default: ;
                    endcase
                    if (rec_we) begin
                        n_uvalid[r_unit] = 1'b1;
                    end
                    if (r_func == FUNC_RELEASE) begin
                        n_uvalid[r_unit] = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_func    <= '0;
            r_unit    <= '0;
            r_now     <= '0;
            r_cnt     <= '0;
            r_last    <= '0;
            r_rd      <= '0;
            r_end     <= '0;
            r_wr      <= '0;
            r_pend    <= 1'b0;
            r_deny1   <= 1'b0;
            r_uvalid  <= '0;
            r_ov      <= 1'b0;
            r_allowed <= 1'b0;
            r_reason  <= REASON_NONE;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_func    <= n_func;
            r_unit    <= n_unit;
            r_now     <= n_now;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_rd      <= n_rd;
            r_end     <= n_end;
            r_wr      <= n_wr;
            r_pend    <= n_pend;
            r_deny1   <= n_deny1;
            r_uvalid  <= n_uvalid;
            r_ov      <= n_ov;
            r_allowed <= n_allowed;
            r_reason  <= n_reason;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= RST_WINDOW_LENGTH;
            r_win_floor <= RST_WINDOW_FLOOR;
            r_att_lim   <= RST_ATTEMPT_LIMIT;
            r_att_floor <= RST_ATTEMPT_FLOOR;
            r_min_gap   <= RST_MIN_GAP;
            r_gap_floor <= RST_GAP_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_LENGTH: r_win_len   <= i_cfg_data;
                CFG_WINDOW_FLOOR:  r_win_floor <= i_cfg_data;
                CFG_ATTEMPT_LIMIT: r_att_lim   <= i_cfg_data[ATT_LIM_W-1:0];
                CFG_ATTEMPT_FLOOR: r_att_floor <= i_cfg_data[ATT_FLOOR_W-1:0];
                CFG_MIN_GAP:       r_min_gap   <= i_cfg_data;
                CFG_GAP_FLOOR:     r_gap_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // attempt time log, one row of LOG_DEPTH entries per unit
    always_ff @(posedge i_clk) begin
        if (log_we) begin
            r_log_mem[log_wa] <= log_wd;
        end
        r_log_q <= r_log_mem[log_ra];
    end

    // per-unit count and last attempt time
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec_mem[r_unit] <= rec_wd;
        end
        if (req_acc) begin
            r_rec_q <= r_rec_mem[req_unit];
        end
    end

endmodule

`default_nettype wire

@@ rtl/rrl_chk.sv @@
// Port-level checks for the restart rate limiter, bound to the top level.
// Depends on rrl_pkg for widths and deny codes.
`default_nettype none

module rrl_chk import rrl_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_req_valid,
    input wire logic                i_req_ready,
    input wire logic                i_rsp_valid,
    input wire logic                i_rsp_ready,
    input wire logic                i_allowed,
    input wire logic [REASON_W-1:0] i_deny_reason,
    input wire logic [COUNT_W-1:0]  i_logged_count
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid right after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken twice in a row");

    a_allowed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_allowed |->
            i_deny_reason == REASON_NONE && i_logged_count < COUNT_W'(LOG_DEPTH))
        else $error("allowed word carries a deny reason or a full log");

    a_reason_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            (i_deny_reason == REASON_NONE || i_deny_reason == REASON_TOO_SOON ||
             i_deny_reason == REASON_LIMIT) && i_logged_count <= COUNT_W'(LOG_DEPTH))
        else $error("bad deny reason or count above log depth");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_allowed) && $stable(i_deny_reason) &&
            $stable(i_logged_count))
        else $error("stalled response word changed");

endmodule

bind restart_rate_limiter_unit rrl_chk #(.LOG_DEPTH(LOG_DEPTH)) u_rrl_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_allowed      (o_rsp.allowed),
    .i_deny_reason  (o_rsp.deny_reason),
    .i_logged_count (o_rsp.logged_count)
);

`default_nettype wire

@@ tb/restart_rate_limiter_unit_tb.sv @@
// Self-checking bench for restart_rate_limiter_unit: drives request words, predicts
// each verdict in a scoreboard class and compares every response word.
// Needs rrl_pkg, rrl_req_if, rrl_rsp_if.
`timescale 1ns / 100ps

module restart_rate_limiter_unit_tb;
    import rrl_pkg::*;

    localparam int UNITS        = NUM_UNITS_DEF;
    localparam int DEPTH        = LOG_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT  = 3000;
    localparam int BLOCK_WORDS  = 121;

    localparam logic [FUNC_W-1:0]    FUNC_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 3'd6;

    typedef struct packed {
        logic                allowed;
        logic [REASON_W-1:0] reason;
        logic [COUNT_W-1:0]  count;
    } t_verdict;

    typedef struct packed {
        logic [15:0] win_len, win_floor, att_lim, att_floor, gap_min, gap_floor;
        logic [31:0] step_max;
    } t_setting;

    class verdict_board;
        logic [NOW_W-1:0]       stamp [UNITS][DEPTH];
        logic [COUNT_W-1:0]     fill [UNITS];
        logic [NOW_W-1:0]       last_try [UNITS];
        logic [SEC_W-1:0]       win_len, win_floor, gap_min, gap_floor;
        logic [ATT_LIM_W-1:0]   att_lim;
        logic [ATT_FLOOR_W-1:0] att_floor;
        t_verdict               verdict_q [$];
        int errors, words_in, n_allowed, n_soon, n_limit, n_record, n_release;

        function new();
            foreach (fill[u]) begin
                fill[u] = '0;
                last_try[u] = '0;
            end
            foreach (stamp[a, b]) stamp[a][b] = '0;
            win_len   = RST_WINDOW_LENGTH;
            win_floor = RST_WINDOW_FLOOR;
            att_lim   = RST_ATTEMPT_LIMIT;
            att_floor = RST_ATTEMPT_FLOOR;
            gap_min   = RST_MIN_GAP;
            gap_floor = RST_GAP_FLOOR;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_WINDOW_LENGTH: win_len   = data;
                CFG_WINDOW_FLOOR:  win_floor = data;
                CFG_ATTEMPT_LIMIT: att_lim   = data[ATT_LIM_W-1:0];
                CFG_ATTEMPT_FLOOR: att_floor = data[ATT_FLOOR_W-1:0];
                CFG_MIN_GAP:       gap_min   = data;
                CFG_GAP_FLOOR:     gap_floor = data;
                default: ;
            endcase
        endfunction

        function int outstanding();
            return verdict_q.size();
        endfunction

        function void predict_word(logic [FUNC_W-1:0] f, logic [UNIT_ID_W-1:0] u,
                                   logic [NOW_W-1:0] now);
            t_verdict         v;
            int               lim, kept, i;
            logic [SEC_W-1:0] gap, win;
            v   = '0;
            lim = (int'(att_lim) > int'(att_floor)) ? int'(att_lim) : int'(att_floor);
            if (lim > DEPTH) lim = DEPTH;
            words_in++;
            case (f)
                FUNC_CHECK: begin
                    gap = (gap_min > gap_floor) ? gap_min : gap_floor;
                    win = (win_len > win_floor) ? win_len : win_floor;
                    if (last_try[u] != 0 &&
                        (now < last_try[u] || now - last_try[u] < gap)) begin
                        v.reason = REASON_TOO_SOON;
                        n_soon++;
                    end else begin
                        kept = 0;
                        // compact the log, keeping future stamps
                        for (i = 0; i < int'(fill[u]) && i < DEPTH; i++) begin
                            if (stamp[u][i] > now || now - stamp[u][i] < win) begin
                                stamp[u][kept] = stamp[u][i];
                                kept++;
                            end
                        end
                        if (kept > lim) kept = lim;
                        fill[u] = COUNT_W'(kept);
                        if (kept >= lim) begin
                            v.reason = REASON_LIMIT;
                            n_limit++;
                        end else begin
                            v.allowed = 1'b1;
                            n_allowed++;
                        end
                    end
                end
                FUNC_RECORD: begin
                    n_record++;
                    if (int'(fill[u]) < lim) begin
                        stamp[u][fill[u]] = now;
                        fill[u] = fill[u] + 1'b1;
                    end else if (lim > 0) begin
                        for (i = 0; i + 1 < lim; i++) stamp[u][i] = stamp[u][i+1];
                        stamp[u][lim-1] = now;
                        fill[u] = COUNT_W'(lim);
                    end
                    last_try[u] = now;
                end
                FUNC_RELEASE: begin
                    n_release++;
                    for (i = 0; i < DEPTH; i++) stamp[u][i] = '0;
                    fill[u] = '0;
                    last_try[u] = '0;
                end
                default: ;
            endcase
            v.count = fill[u];
            verdict_q.push_back(v);
        endfunction

        function void check_word(logic allowed, logic [REASON_W-1:0] reason,
                                 logic [COUNT_W-1:0] count);
            t_verdict exp_v;
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result word allowed=%0d reason=%0d count=%0d",
                         $time, allowed, reason, count);
                errors++;
                return;
            end
            exp_v = verdict_q.pop_front();
            if (allowed !== exp_v.allowed || reason !== exp_v.reason ||
                count !== exp_v.count) begin
                $display({"%0t: mismatch: expected allowed=%0d reason=%0d count=%0d,",
                          " got allowed=%0d reason=%0d count=%0d"},
                         $time, exp_v.allowed, exp_v.reason, exp_v.count,
                         allowed, reason, count);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    rrl_req_if req_if ();
    rrl_rsp_if rsp_if ();

    verdict_board verdicts = new();
    t_setting     plan [6];
    int           send_idle_pct = 21;
    int           rsp_stall_pct = 85;
    int           quiet_cycles = 0;
    int           failures;

    restart_rate_limiter_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        req_if.valid   = 1'b0;
        req_if.func    = FUNC_CHECK;
        req_if.unit_id = '0;
        req_if.now_sec = '0;
        rsp_if.ready   = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                verdicts.predict_word(req_if.func, req_if.unit_id, req_if.now_sec);
            if (rsp_if.valid && rsp_if.ready)
                verdicts.check_word(rsp_if.allowed, rsp_if.deny_reason,
                                    rsp_if.logged_count);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("restart_rate_limiter_unit_tb: done, errors");
            $finish;
        end
    end

    // hold a word until taken, then idle the sender at random
    task put_word(logic [FUNC_W-1:0] f, logic [UNIT_ID_W-1:0] u, logic [NOW_W-1:0] t);
        req_if.valid   <= 1'b1;
        req_if.func    <= f;
        req_if.unit_id <= u;
        req_if.now_sec <= t;
        do @(posedge i_clk); while (!req_if.ready);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // let the monitor log the last accepted word before waiting for the drain
    task settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (verdicts.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        verdicts.load_register(idx, data);
        @(posedge i_clk);
    endtask

    task apply_setting(t_setting s);
        write_reg(CFG_WINDOW_LENGTH, s.win_len);
        write_reg(CFG_WINDOW_FLOOR, s.win_floor);
        write_reg(CFG_ATTEMPT_LIMIT, s.att_lim);
        write_reg(CFG_ATTEMPT_FLOOR, s.att_floor);
        write_reg(CFG_MIN_GAP, s.gap_min);
        write_reg(CFG_GAP_FLOOR, s.gap_floor);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));   // no such register, must change nothing
        i_cfg_we <= 1'b0;
    endtask

    // mostly check-then-record attempts on a few busy units, the rest noise
    task run_block(int n, int step_max);
        logic [NOW_W-1:0]     t;
        logic [UNIT_ID_W-1:0] u;
        int                   k, kind, focus;
        t     = $urandom();
        focus = int'($urandom_range(UNITS - 1));
        k     = 0;
        while (k < n) begin
            t    = t + $urandom_range(step_max);
            u    = ($urandom_range(99) < 80) ?
                       UNIT_ID_W'((focus + $urandom_range(3)) % UNITS) :
                       UNIT_ID_W'($urandom_range(UNITS - 1));
            kind = $urandom_range(99);
            if (kind < 55) begin
                put_word(FUNC_CHECK, u, t);
                put_word(FUNC_RECORD, u, t);
                k += 2;
            end else begin
                if (kind < 70)      put_word(FUNC_CHECK, u, t);
                else if (kind < 82) put_word(FUNC_RECORD, u, t);
                else if (kind < 88) put_word(FUNC_RELEASE, u, t);
                else if (kind < 92) put_word(FUNC_UNUSED, u, t);
                else if (kind < 96) put_word(FUNC_CHECK, u, t - $urandom_range(1, 20));
                else                put_word(FUNC_W'($urandom_range(3)),
                                             UNIT_ID_W'($urandom_range(UNITS - 1)),
                                             $urandom());
                k++;
            end
        end
    endtask

    initial begin
        int m, s;
        plan[0] = '{16'd0,     16'd12,    16'd0,     16'd3,     16'd0,     16'd2,     32'd4};
        plan[1] = '{16'd65535, 16'd1,     16'd255,   16'd32,    16'd3,     16'd1,     32'd12000};
        // attempt floor written as zero through its low bits: zero limit
        plan[2] = '{16'd0,     16'hFFFF,  16'hFF00,  16'hFFC0,  16'd0,     16'd1,     32'd5};
        plan[3] = '{16'd20,    16'd1,     16'hAB04,  16'd1,     16'd65535, 16'd65535, 32'd40000};
        plan[4] = '{16'd30,    16'd5,     16'd6,     16'd32,    16'd1,     16'd1,     32'd8};
        plan[5] = '{16'd9,     16'd10,    16'd2,     16'h0041,  16'd0,     16'd3,     32'd3};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset settings: window 10, limit 5, gap 1
        put_word(FUNC_CHECK, 4'd0, 32'd100);
        put_word(FUNC_RECORD, 4'd0, 32'd100);
        put_word(FUNC_CHECK, 4'd0, 32'd100);          // inside the gap
        put_word(FUNC_CHECK, 4'd0, 32'd99);           // clock went backwards
        put_word(FUNC_RECORD, 4'd0, 32'd101);
        put_word(FUNC_RECORD, 4'd0, 32'd102);
        put_word(FUNC_RECORD, 4'd0, 32'd103);
        put_word(FUNC_RECORD, 4'd0, 32'd104);
        put_word(FUNC_CHECK, 4'd0, 32'd105);          // log full
        put_word(FUNC_RECORD, 4'd0, 32'd106);         // oldest drops out
        put_word(FUNC_CHECK, 4'd0, 32'd200);          // whole log aged out
        put_word(FUNC_UNUSED, 4'd0, 32'hFFFF_FFFF);
        put_word(FUNC_RECORD, 4'd15, 32'd0);          // time zero keeps last as never
        put_word(FUNC_CHECK, 4'd15, 32'd0);
        put_word(FUNC_RECORD, 4'd15, 32'hFFFF_FFFF);
        put_word(FUNC_CHECK, 4'd15, 32'd5);
        put_word(FUNC_RELEASE, 4'd15, 32'd5);
        put_word(FUNC_CHECK, 4'd15, 32'd5);
        put_word(FUNC_RECORD, 4'd1, 32'd50);
        put_word(FUNC_CHECK, 4'd1, 32'd40);
        put_word(FUNC_RECORD, 4'd2, 32'd60);
        put_word(FUNC_RECORD, 4'd2, 32'd0);
        put_word(FUNC_CHECK, 4'd2, 32'd30);           // future stamp stays, old one ages out

        for (m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 21 : (m == 1) ? 85 : 0;
            rsp_stall_pct = (m == 0) ? 85 : (m == 1) ? 21 : 0;
            for (s = 0; s < 2; s++) begin
                settle();
                apply_setting(plan[2*m + s]);
                run_block(BLOCK_WORDS, plan[2*m + s].step_max);
            end
        end
        settle();

        failures = verdicts.errors + verdicts.outstanding();
        $display({"covered %0d words: %0d checks allowed, %0d too soon, %0d at limit,",
                  " %0d records, %0d releases"},
                 verdicts.words_in, verdicts.n_allowed, verdicts.n_soon, verdicts.n_limit,
                 verdicts.n_record, verdicts.n_release);
        $display("six register settings incl. zero limit and truncated writes, three pacing modes");
        if (failures == 0)
            $display("restart_rate_limiter_unit_tb: done, clean");
        else
            $display("restart_rate_limiter_unit_tb: done, errors");
        $finish;
    end

endmodule
